>>> sv/byte_frequency_histogram_defines.svh
// Assertion macros shared by the histogram checker.
// No dependencies; expects clk and rst in the scope of use.
`ifndef BYTE_FREQUENCY_HISTOGRAM_DEFINES_SVH
`define BYTE_FREQUENCY_HISTOGRAM_DEFINES_SVH

// Ordinary property, switched off while reset is high.
`define BFH_ASSERT(name, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("bfh checker: property failed");

// Property that must also hold across reset.
`define BFH_ASSERT_RST(name, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("bfh checker: reset property failed");

`endif

>>> sv/bfh_pkg.sv
// Package for the byte frequency histogram: field widths, beat layout,
// item kinds, sequencer states and the scan control struct. No dependencies.
package bfh_pkg;

  localparam int SYMBOLS_DEF    = 256;
  localparam int COUNT_BITS_DEF = 32;

  // field widths of the stream beats
  localparam int KIND_W     = 3;
  localparam int SYMBOL_W   = 8;
  localparam int COUNT_W    = 32;
  localparam int DISTINCT_W = 9;

  localparam int S_TDATA_W  = 40;  // symbol + load_count, whole bytes
  localparam int M_TDATA_RAW = SYMBOL_W + COUNT_W + COUNT_W + DISTINCT_W;
  localparam int M_TDATA_W  = 88;  // 81 bits rounded up to bytes
  localparam int OUT_PAD_W  = M_TDATA_W - M_TDATA_RAW;

  typedef enum logic [KIND_W-1:0] {
    KIND_COUNT   = 3'd0,
    KIND_CLEAR   = 3'd1,
    KIND_SUMMARY = 3'd2,
    KIND_NEXT    = 3'd3,
    KIND_LOAD    = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_SCAN,
    ST_DONE
  } state_t;

  // sequencer -> scan unit
  typedef struct packed {
    logic start;       // reset the accumulators
    logic find_first;  // next-nonzero search rather than summary
    logic check;       // a bin word is present on the read port
  } scan_ctrl_t;

endpackage

>>> sv/byte_frequency_histogram.sv
// Byte frequency histogram: top level with the item sequencer.
// Depends on bfh_pkg, bfh_ram and bfh_scan.
//
// Keeps one saturating counter per symbol in a RAM plus a saturating byte
// total, and serves the five item kinds on tuser. The block takes one item
// at a time; s_tready is high only while the sequencer is idle. The work per
// item is set by the single read and write port of the bin RAM and the one
// shared compare unit that walks it: a count reads the bin, then writes back
// the incremented bin; a load, an unknown kind and an out-of-range count or
// load are done in the idle state; a clear is a sweep writing zero to every
// bin, one a cycle; summary and next (from the symbol on) read one bin per
// cycle, then check the last read word, close the scan and load the result
// register, plus any wait for a result beat still held on the master side.
// After reset the same clearing sweep runs before the first beat is taken.
// Results sit in an output register, so a count, load or clear can be taken
// while a result beat waits for m_tready.
module byte_frequency_histogram #(
  parameter int SYMBOLS    = bfh_pkg::SYMBOLS_DEF,
  parameter int COUNT_BITS = bfh_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // slave side
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // [7:0] symbol, [39:8] load_count
  input  logic [bfh_pkg::S_TDATA_W-1:0]  s_tdata,
  // [2:0] kind
  input  logic [bfh_pkg::KIND_W-1:0]     s_tuser,
  // master side
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // [7:0] found_symbol, [39:8] found_count, [71:40] total_bytes,
  // [80:72] distinct_symbols, [87:81] zero
  output logic [bfh_pkg::M_TDATA_W-1:0]  m_tdata,
  // [0] found
  output logic [0:0]                     m_tuser
);
  import bfh_pkg::*;

  localparam int SYM_BITS = $clog2(SYMBOLS);
  localparam int IDX_W    = SYM_BITS + 1;

  // beat fields
  logic [SYMBOL_W-1:0] in_symbol;
  logic [COUNT_W-1:0]  in_load;
  kind_t               in_kind;
  logic                in_fire;
  logic                sym_ok;

  assign in_symbol = s_tdata[SYMBOL_W-1:0];
  assign in_load   = s_tdata[SYMBOL_W +: COUNT_W];
  assign in_kind   = kind_t'(s_tuser);
  assign in_fire   = s_tvalid && s_tready;
  assign sym_ok    = (32'(in_symbol) < SYMBOLS);

  // sequencer state
  state_t              state, state_next;
  logic [IDX_W-1:0]    idx, idx_next;    // sweep / scan address
  logic [SYM_BITS-1:0] cur_addr;         // bin being incremented
  logic                is_next;          // current scan is a next search
  logic [COUNT_BITS-1:0] total;
  logic                chk_valid;        // read data is a scanned bin
  logic [SYM_BITS-1:0] chk_idx;
  logic                issue;
  logic                load_out;

  // RAM port
  logic                  ram_we;
  logic [SYM_BITS-1:0]   ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [SYM_BITS-1:0]   ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  // scan unit
  scan_ctrl_t            scan_ctrl;
  logic [SYM_BITS-1:0]   best_sym;
  logic [COUNT_BITS-1:0] best_cnt;
  logic [SYM_BITS:0]     distinct;
  logic                  hit;

  // output register
  logic                  out_valid;
  logic [SYMBOL_W-1:0]   out_sym;
  logic [COUNT_W-1:0]    out_count;
  logic [COUNT_W-1:0]    out_total;
  logic [DISTINCT_W-1:0] out_distinct;
  logic                  out_found;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    idx_next   = idx;
    ram_we     = 1'b0;
    ram_waddr  = cur_addr;
    ram_wdata  = '0;
    ram_raddr  = idx[SYM_BITS-1:0];
    issue      = 1'b0;
    load_out   = 1'b0;
    scan_ctrl.start      = 1'b0;
    scan_ctrl.find_first = is_next;
    scan_ctrl.check      = chk_valid;
    case (state)
      ST_CLEAR: begin
        // zero one bin a cycle
        ram_we    = 1'b1;
        ram_waddr = idx[SYM_BITS-1:0];
        if (idx == IDX_W'(SYMBOLS - 1)) begin
          state_next = ST_IDLE;
          idx_next   = '0;
        end else begin
          idx_next = idx + 1'b1;
        end
      end
      ST_IDLE: begin
        // read the addressed bin speculatively for a count beat
        ram_raddr = SYM_BITS'(in_symbol);
        if (in_fire) begin
          case (in_kind)
            KIND_COUNT: begin
              if (sym_ok) begin
                state_next = ST_INC;
              end
            end
            KIND_CLEAR: begin
              state_next = ST_CLEAR;
              idx_next   = '0;
            end
            KIND_LOAD: begin
              if (sym_ok) begin
                ram_we    = 1'b1;
                ram_waddr = SYM_BITS'(in_symbol);
                ram_wdata = COUNT_BITS'(in_load);
              end
            end
            KIND_SUMMARY: begin
              state_next      = ST_SCAN;
              idx_next        = '0;
              scan_ctrl.start = 1'b1;
            end
            KIND_NEXT: begin
              state_next      = ST_SCAN;
              // start beyond the table finds nothing
              idx_next        = sym_ok ? IDX_W'(in_symbol) : IDX_W'(SYMBOLS);
              scan_ctrl.start = 1'b1;
            end
            default: ;
          endcase
        end
      end
      ST_INC: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
        state_next = ST_IDLE;
      end
      ST_SCAN: begin
        issue = (idx < IDX_W'(SYMBOLS));
        if (issue) begin
          idx_next = idx + 1'b1;
        end else if (!chk_valid) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
        idx_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      idx       <= '0;
      total     <= '0;
      chk_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      idx       <= idx_next;
      chk_valid <= issue;
      if (in_fire && in_kind == KIND_CLEAR) begin
        total <= '0;
      end else if (in_fire && in_kind == KIND_COUNT && sym_ok && total != '1) begin
        total <= total + 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    chk_idx <= idx[SYM_BITS-1:0];
    if (in_fire) begin
      cur_addr <= SYM_BITS'(in_symbol);
      is_next  <= (in_kind == KIND_NEXT);
    end
    if (load_out) begin
      out_sym      <= SYMBOL_W'(best_sym);
      out_count    <= COUNT_W'(best_cnt);
      out_total    <= is_next ? '0 : COUNT_W'(total);
      out_distinct <= is_next ? '0 : DISTINCT_W'(distinct);
      out_found    <= is_next && hit;
    end
  end

  bfh_ram #(
    .DEPTH  (SYMBOLS),
    .ADDR_W (SYM_BITS),
    .DATA_W (COUNT_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bfh_scan #(
    .SYM_BITS   (SYM_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_scan (
    .clk      (clk),
    .ctrl     (scan_ctrl),
    .chk_idx  (chk_idx),
    .chk_data (ram_rdata),
    .best_sym (best_sym),
    .best_cnt (best_cnt),
    .distinct (distinct),
    .hit      (hit)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {{OUT_PAD_W{1'b0}}, out_distinct, out_total, out_count, out_sym};
  assign m_tuser  = out_found;

endmodule

>>> sv/bfh_ram.sv
// Simple dual-port bin store: one write port, one registered read port.
// No dependencies.
module bfh_ram #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bfh_scan.sv
// Shared compare/accumulate unit used by summary and next-nonzero scans.
// Depends on bfh_pkg (scan_ctrl_t).
module bfh_scan #(
  parameter int SYM_BITS   = 8,
  parameter int COUNT_BITS = 32
) (
  input  logic                  clk,
  input  bfh_pkg::scan_ctrl_t   ctrl,
  input  logic [SYM_BITS-1:0]   chk_idx,
  input  logic [COUNT_BITS-1:0] chk_data,
  output logic [SYM_BITS-1:0]   best_sym,
  output logic [COUNT_BITS-1:0] best_cnt,
  output logic [SYM_BITS:0]     distinct,
  output logic                  hit
);
  import bfh_pkg::*;

  logic nonzero;
  logic greater;

  assign nonzero = (chk_data != '0);
  assign greater = (chk_data > best_cnt);

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      best_sym <= '0;
      best_cnt <= '0;
      distinct <= '0;
      hit      <= 1'b0;
    end else if (ctrl.check) begin
      if (ctrl.find_first) begin
        // first nonzero bin wins, later ones ignored
        if (!hit && nonzero) begin
          hit      <= 1'b1;
          best_sym <= chk_idx;
          best_cnt <= chk_data;
        end
      end else begin
        if (nonzero) begin
          distinct <= distinct + 1'b1;
        end
        // strict compare keeps the lowest symbol on a tie
        if (greater) begin
          best_sym <= chk_idx;
          best_cnt <= chk_data;
        end
      end
    end
  end

endmodule

>>> sv/bfh_checker.sv
// Port-level checker for the byte frequency histogram, with its bind.
// Depends on bfh_pkg and byte_frequency_histogram_defines.svh.
`include "byte_frequency_histogram_defines.svh"

module bfh_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic [bfh_pkg::KIND_W-1:0]     s_tuser,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [bfh_pkg::M_TDATA_W-1:0]  m_tdata,
  input logic [0:0]                     m_tuser
);
  import bfh_pkg::*;

  logic s_fire;
  logic scan_beat;
  assign s_fire    = s_tvalid && s_tready;
  assign scan_beat = s_fire && (s_tuser == KIND_SUMMARY || s_tuser == KIND_NEXT);

  // a held result beat stays offered
  `BFH_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid)

  // reset starts the clearing sweep, so no beat is taken straight after
  `BFH_ASSERT_RST(a_rst_sweep, rst |=> !s_tready)

  // a clear beat starts a sweep
  `BFH_ASSERT(a_clear_busy, s_fire && s_tuser == KIND_CLEAR |=> !s_tready)

  // summary and next beats start a scan
  `BFH_ASSERT(a_scan_busy, scan_beat |=> !s_tready)

  // a found result comes from a next search: total and distinct read zero
  `BFH_ASSERT(a_found_fields, m_tvalid && m_tuser[0] |-> m_tdata[80:40] == 41'd0)

endmodule

bind byte_frequency_histogram bfh_checker u_bfh_checker (.*);
